>>> hdl/hce_pkg.sv
// Shared types, constants and the feature term table of the cascade evaluator.
`timescale 1ns / 1ps
package hce_pkg;

  localparam int IMG_ROWS     = 64;
  localparam int IMG_COLS     = 64;
  localparam int MAX_FEATURES = 1024;
  localparam int MAX_STAGES   = 32;

  localparam int PIX_AW  = $clog2(IMG_ROWS * IMG_COLS);
  localparam int FEAT_AW = $clog2(MAX_FEATURES);
  localparam int STG_AW  = $clog2(MAX_STAGES);

  localparam logic [2:0] ACT_WR_INT   = 3'd0;
  localparam logic [2:0] ACT_WR_SQ    = 3'd1;
  localparam logic [2:0] ACT_WR_FEAT  = 3'd2;
  localparam logic [2:0] ACT_WR_STAGE = 3'd3;
  localparam logic [2:0] ACT_EVAL     = 3'd4;

  localparam logic [2:0] CFG_WIN_ROWS = 3'd0;
  localparam logic [2:0] CFG_WIN_COLS = 3'd1;
  localparam logic [2:0] CFG_MEAN_LO  = 3'd2;
  localparam logic [2:0] CFG_MEAN_HI  = 3'd3;
  localparam logic [2:0] CFG_SQ_LO    = 3'd4;
  localparam logic [2:0] CFG_DEV_LO   = 3'd5;
  localparam logic [2:0] CFG_STAGES   = 3'd6;
  localparam logic [2:0] CFG_INV_AREA = 3'd7;

  typedef struct packed {
    logic [2:0]         action;
    logic [5:0]         row;
    logic [5:0]         col;
    logic [39:0]        entry_value;
    logic [9:0]         slot;
    logic [2:0]         feature_kind;
    logic [39:0]        feature_offsets;
    logic               feature_parity;
    logic signed [31:0] feature_threshold;
    logic signed [31:0] weight;
    logic [9:0]         feature_count;
  } item_t;

  typedef struct packed {
    logic [5:0] window_row;
    logic [5:0] window_col;
    logic       detected;
    logic       prefiltered;
    logic [5:0] stages_passed;
  } result_t;

  typedef struct packed {
    logic [2:0]         kind;
    logic [39:0]        offsets;
    logic               parity;
    logic signed [31:0] thresh;
    logic signed [31:0] alpha;
  } feat_t;

  typedef struct packed {
    logic [9:0]         count;
    logic signed [31:0] thresh;
  } stage_t;

  // One corner read of a feature: which x and y offset, sign and magnitude.
  typedef struct packed {
    logic [1:0] xs;
    logic [1:0] ys;
    logic       neg;
    logic [2:0] mag;
  } term_t;

  function automatic term_t mk(logic [1:0] xs, logic [1:0] ys, logic neg, logic [2:0] mag);
    term_t t;
    t.xs = xs; t.ys = ys; t.neg = neg; t.mag = mag;
    return t;
  endfunction

  function automatic term_t term_of(logic [2:0] kind, logic [3:0] j);
    term_t t;
    t = mk(2'd0, 2'd0, 1'b0, 3'd0);
    case (kind)
      3'd0: case (j)
        4'd0: t = mk(2'd0, 2'd2, 1'b0, 3'd1);
        4'd1: t = mk(2'd0, 2'd0, 1'b1, 3'd1);
        4'd2: t = mk(2'd2, 2'd2, 1'b0, 3'd1);
        4'd3: t = mk(2'd2, 2'd0, 1'b1, 3'd1);
        4'd4: t = mk(2'd1, 2'd0, 1'b0, 3'd2);
        4'd5: t = mk(2'd1, 2'd2, 1'b1, 3'd2);
        default: ;
      endcase
      3'd1: case (j)
        4'd0: t = mk(2'd2, 2'd0, 1'b0, 3'd1);
        4'd1: t = mk(2'd2, 2'd2, 1'b0, 3'd1);
        4'd2: t = mk(2'd0, 2'd0, 1'b1, 3'd1);
        4'd3: t = mk(2'd0, 2'd2, 1'b1, 3'd1);
        4'd4: t = mk(2'd0, 2'd1, 1'b0, 3'd2);
        4'd5: t = mk(2'd2, 2'd1, 1'b1, 3'd2);
        default: ;
      endcase
      3'd2: case (j)
        4'd0: t = mk(2'd0, 2'd0, 1'b0, 3'd1);
        4'd1: t = mk(2'd0, 2'd2, 1'b1, 3'd1);
        4'd2: t = mk(2'd3, 2'd2, 1'b0, 3'd1);
        4'd3: t = mk(2'd3, 2'd0, 1'b1, 3'd1);
        4'd4: t = mk(2'd1, 2'd2, 1'b0, 3'd3);
        4'd5: t = mk(2'd1, 2'd0, 1'b1, 3'd3);
        4'd6: t = mk(2'd2, 2'd0, 1'b0, 3'd3);
        4'd7: t = mk(2'd2, 2'd2, 1'b1, 3'd3);
        default: ;
      endcase
      3'd3: case (j)
        4'd0: t = mk(2'd0, 2'd0, 1'b0, 3'd1);
        4'd1: t = mk(2'd0, 2'd3, 1'b1, 3'd1);
        4'd2: t = mk(2'd2, 2'd3, 1'b0, 3'd1);
        4'd3: t = mk(2'd2, 2'd0, 1'b1, 3'd1);
        4'd4: t = mk(2'd2, 2'd1, 1'b0, 3'd3);
        4'd5: t = mk(2'd2, 2'd2, 1'b1, 3'd3);
        4'd6: t = mk(2'd0, 2'd2, 1'b0, 3'd3);
        4'd7: t = mk(2'd0, 2'd1, 1'b1, 3'd3);
        default: ;
      endcase
      3'd4: case (j)
        4'd0: t = mk(2'd0, 2'd0, 1'b0, 3'd1);
        4'd1: t = mk(2'd0, 2'd2, 1'b0, 3'd1);
        4'd2: t = mk(2'd2, 2'd0, 1'b0, 3'd1);
        4'd3: t = mk(2'd2, 2'd2, 1'b0, 3'd1);
        4'd4: t = mk(2'd1, 2'd0, 1'b1, 3'd2);
        4'd5: t = mk(2'd1, 2'd2, 1'b1, 3'd2);
        4'd6: t = mk(2'd0, 2'd1, 1'b1, 3'd2);
        4'd7: t = mk(2'd2, 2'd1, 1'b1, 3'd2);
        4'd8: t = mk(2'd1, 2'd1, 1'b0, 3'd4);
        default: ;
      endcase
      default: ;
    endcase
    return t;
  endfunction

endpackage

>>> hdl/hce_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module hce_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hdl/haar_cascade_window_evaluator.sv
// Top level: Haar cascade evaluation of one window over stored integral images.
//
// Write items (integral, squared integral, feature, stage) are taken without
// leaving idle and give no result. An evaluate item keeps busy high while a
// sequencer drives one shared 33x33 signed multiplier, a bit-pair square root
// and single-port reads of the stores: the window box sums, then mean and
// variance, the square root, then per stage a stage read and a threshold check
// and per feature nine integral reads, a multiply and a compare, so the total
// grows with the number of features walked before rejection.
// The result is shown for one cycle with done; the receiver cannot stall it,
// and a new item may be started in that same cycle.
`timescale 1ns / 1ps
module haar_cascade_window_evaluator (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  input  hce_pkg::item_t  item,
  output logic            done,
  output hce_pkg::result_t result,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [2:0]      cfg_index,
  input  logic [31:0]     cfg_data
);
  import hce_pkg::*;

  localparam logic [4:0] S_IDLE    = 5'd0;
  localparam logic [4:0] S_BOX_A   = 5'd1;
  localparam logic [4:0] S_BOX_B   = 5'd2;
  localparam logic [4:0] S_PRE     = 5'd3;
  localparam logic [4:0] S_M1      = 5'd4;
  localparam logic [4:0] S_M2      = 5'd5;
  localparam logic [4:0] S_M3      = 5'd6;
  localparam logic [4:0] S_M4      = 5'd7;
  localparam logic [4:0] S_M5      = 5'd8;
  localparam logic [4:0] S_M6      = 5'd9;
  localparam logic [4:0] S_SQRT    = 5'd10;
  localparam logic [4:0] S_DEV     = 5'd11;
  localparam logic [4:0] S_STG_A   = 5'd12;
  localparam logic [4:0] S_STG_B   = 5'd13;
  localparam logic [4:0] S_FT_CHK  = 5'd14;
  localparam logic [4:0] S_FT_RD   = 5'd15;
  localparam logic [4:0] S_TERM_A  = 5'd16;
  localparam logic [4:0] S_TERM_B  = 5'd17;
  localparam logic [4:0] S_FT_MUL  = 5'd18;
  localparam logic [4:0] S_FT_CMP  = 5'd19;
  localparam logic [4:0] S_STG_END = 5'd20;

  // configuration
  logic [5:0]  window_rows, window_cols, stages_in_use;
  logic [23:0] mean_low, mean_high, inverse_area;
  logic [31:0] square_low;
  logic [7:0]  deviation_low;

  logic [4:0] state;
  logic       fire;

  // evaluation registers
  logic [5:0]         win_r, win_c;
  logic [3:0]         j;
  logic               oob_q, neg_q;
  logic [2:0]         mag_q;
  logic signed [42:0] ex_acc, sq_acc;
  logic signed [45:0] f_acc;
  logic [25:0]        m_q;
  logic [39:0]        msq_q;
  logic [52:0]        t1_q;
  logic [63:0]        sq_v, sq_res, sq_bit;
  logic               var_zero;
  logic [27:0]        dev_q;
  logic [5:0]         k, nst, passed;
  logic [9:0]         t_cnt;
  logic [FEAT_AW-1:0] fi;
  logic signed [47:0] sum;
  feat_t              feat_q;
  stage_t             stg_q;

  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] mul_p;

  logic [39:0]  int_rd, sq_rd;
  logic [107:0] feat_rd;
  logic [41:0]  stg_rd;

  assign fire      = start && !busy;
  assign busy      = (state != S_IDLE);
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_rows   <= 6'd24;
      window_cols   <= 6'd24;
      mean_low      <= 24'd0;
      mean_high     <= 24'hFFFFFF;
      square_low    <= 32'd0;
      deviation_low <= 8'd0;
      stages_in_use <= 6'd0;
      inverse_area  <= 24'd26843;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_WIN_ROWS: window_rows   <= cfg_data[5:0];
        CFG_WIN_COLS: window_cols   <= cfg_data[5:0];
        CFG_MEAN_LO:  mean_low      <= cfg_data[23:0];
        CFG_MEAN_HI:  mean_high     <= cfg_data[23:0];
        CFG_SQ_LO:    square_low    <= cfg_data;
        CFG_DEV_LO:   deviation_low <= cfg_data[7:0];
        CFG_STAGES:   stages_in_use <= cfg_data[5:0];
        CFG_INV_AREA: inverse_area  <= cfg_data[23:0];
        default: ;
      endcase
    end
  end

  // store writes
  logic              wr_in_img, int_we, sq_we, feat_we, stg_we;
  logic [PIX_AW-1:0] wr_addr;
  feat_t             feat_wd;
  stage_t            stg_wd;

  assign wr_in_img = (32'(item.row) < IMG_ROWS) && (32'(item.col) < IMG_COLS);
  assign wr_addr   = PIX_AW'(32'(item.row) * IMG_COLS + 32'(item.col));
  assign int_we    = fire && item.action == ACT_WR_INT && wr_in_img;
  assign sq_we     = fire && item.action == ACT_WR_SQ && wr_in_img;
  assign feat_we   = fire && item.action == ACT_WR_FEAT && 32'(item.slot) < MAX_FEATURES;
  assign stg_we    = fire && item.action == ACT_WR_STAGE && 32'(item.slot) < MAX_STAGES;

  always_comb begin
    feat_wd.kind    = item.feature_kind;
    feat_wd.offsets = item.feature_offsets;
    feat_wd.parity  = item.feature_parity;
    feat_wd.thresh  = item.feature_threshold;
    feat_wd.alpha   = item.weight;
    stg_wd.count    = item.feature_count;
    stg_wd.thresh   = item.weight;
  end

  // read address of the current corner term
  term_t             tm;
  logic [4:0]        xo, yo;
  logic [6:0]        rd_x, rd_y;
  logic              rd_oob;
  logic [PIX_AW-1:0] rd_addr;
  logic              rd_neg;
  logic [2:0]        rd_mag;

  always_comb begin
    tm     = term_of(feat_q.kind, j);
    xo     = feat_q.offsets[5 * tm.xs +: 5];
    yo     = feat_q.offsets[5 * (4 + 32'(tm.ys)) +: 5];
    rd_neg = tm.neg;
    rd_mag = tm.mag;
    rd_x   = 7'(win_r) + 7'(xo);
    rd_y   = 7'(win_c) + 7'(yo);
    if (state == S_BOX_A || state == S_BOX_B) begin
      rd_mag = 3'd1;
      case (j[1:0])
        2'd0: begin
          rd_x = 7'(win_r) + 7'(window_rows); rd_y = 7'(win_c) + 7'(window_cols);
          rd_neg = 1'b0;
        end
        2'd1: begin
          rd_x = 7'(win_r); rd_y = 7'(win_c); rd_neg = 1'b0;
        end
        2'd2: begin
          rd_x = 7'(win_r) + 7'(window_rows); rd_y = 7'(win_c); rd_neg = 1'b1;
        end
        default: begin
          rd_x = 7'(win_r); rd_y = 7'(win_c) + 7'(window_cols); rd_neg = 1'b1;
        end
      endcase
    end
    rd_oob  = (32'(rd_x) >= IMG_ROWS) || (32'(rd_y) >= IMG_COLS);
    rd_addr = PIX_AW'(32'(rd_x) * IMG_COLS + 32'(rd_y));
  end

  hce_ram #(.WIDTH(40), .DEPTH(IMG_ROWS * IMG_COLS)) u_int_ram (
    .clk(clk), .we(int_we), .waddr(wr_addr), .wdata(item.entry_value),
    .raddr(rd_addr), .rdata(int_rd)
  );

  hce_ram #(.WIDTH(40), .DEPTH(IMG_ROWS * IMG_COLS)) u_sq_ram (
    .clk(clk), .we(sq_we), .waddr(wr_addr), .wdata(item.entry_value),
    .raddr(rd_addr), .rdata(sq_rd)
  );

  hce_ram #(.WIDTH(108), .DEPTH(MAX_FEATURES)) u_feat_ram (
    .clk(clk), .we(feat_we), .waddr(item.slot[FEAT_AW-1:0]), .wdata(feat_wd),
    .raddr(fi), .rdata(feat_rd)
  );

  hce_ram #(.WIDTH(42), .DEPTH(MAX_STAGES)) u_stg_ram (
    .clk(clk), .we(stg_we), .waddr(item.slot[STG_AW-1:0]), .wdata(stg_wd),
    .raddr(k[STG_AW-1:0]), .rdata(stg_rd)
  );

  // shared multiplier operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      S_M1: begin
        mul_a = $signed({9'd0, ex_acc[23:0]}); mul_b = $signed({9'd0, inverse_area});
      end
      S_M3: begin
        mul_a = $signed({7'd0, m_q}); mul_b = $signed({7'd0, m_q});
      end
      S_M4: begin
        mul_a = $signed({4'd0, sq_acc[40:12]}); mul_b = $signed({9'd0, inverse_area});
      end
      S_M5: begin
        mul_a = $signed({21'd0, sq_acc[11:0]}); mul_b = $signed({9'd0, inverse_area});
      end
      S_FT_MUL: begin
        mul_a = $signed({5'd0, dev_q}); mul_b = $signed({feat_q.thresh[31], feat_q.thresh});
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    mul_p <= mul_a * mul_b;
  end

  // datapath helpers
  logic [39:0]        rv_int, rv_sq;
  logic [42:0]        scaled;
  logic [53:0]        sqm, var_w;
  logic [63:0]        sq_trial;
  logic [27:0]        dev_w;
  logic signed [45:0] f_clamp;
  logic signed [65:0] lhs;
  logic               below, take;
  logic               pre_fail;

  always_comb begin
    rv_int   = oob_q ? 40'd0 : int_rd;
    rv_sq    = oob_q ? 40'd0 : sq_rd;
    scaled   = (mag_q[0] ? 43'(rv_int) : 43'd0) + (mag_q[1] ? 43'(rv_int) << 1 : 43'd0)
             + (mag_q[2] ? 43'(rv_int) << 2 : 43'd0);
    sqm      = 54'(t1_q) + 54'(mul_p[35:12]);
    var_w    = (sqm > 54'(msq_q)) ? sqm - 54'(msq_q) : 54'd0;
    sq_trial = sq_res + sq_bit;
    dev_w    = var_zero ? 28'd64 : sq_res[27:0];
    pre_fail = (ex_acc < $signed({19'd0, mean_low})) || (ex_acc > $signed({19'd0, mean_high}))
            || (sq_acc < $signed({11'd0, square_low}));
    if (f_acc > $signed(46'd1 << 40)) begin
      f_clamp = $signed(46'd1 << 40);
    end else if (f_acc < -$signed(46'd1 << 40)) begin
      f_clamp = -$signed(46'd1 << 40);
    end else begin
      f_clamp = f_acc;
    end
    lhs   = $signed({f_clamp[43:0], 22'd0});
    below = lhs < mul_p;
    take  = feat_q.parity ? below : !below;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (fire && item.action == ACT_EVAL) begin
            win_r  <= item.row;
            win_c  <= item.col;
            j      <= 4'd0;
            ex_acc <= '0;
            sq_acc <= '0;
            state  <= S_BOX_A;
          end
        end
        S_BOX_A: begin
          oob_q <= rd_oob;
          neg_q <= rd_neg;
          state <= S_BOX_B;
        end
        S_BOX_B: begin
          ex_acc <= neg_q ? ex_acc - 43'(rv_int) : ex_acc + 43'(rv_int);
          sq_acc <= neg_q ? sq_acc - 43'(rv_sq) : sq_acc + 43'(rv_sq);
          j      <= j + 4'd1;
          state  <= (j == 4'd3) ? S_PRE : S_BOX_A;
        end
        S_PRE: begin
          if (pre_fail) begin
            result.window_row    <= win_r;
            result.window_col    <= win_c;
            result.detected      <= 1'b0;
            result.prefiltered   <= 1'b1;
            result.stages_passed <= 6'd0;
            done  <= 1'b1;
            state <= S_IDLE;
          end else begin
            state <= S_M1;
          end
        end
        S_M1: state <= S_M2;
        S_M2: begin
          // saturate the mean to 26 bits
          m_q   <= (mul_p[47:38] != 10'd0) ? 26'h3FFFFFF : mul_p[37:12];
          state <= S_M3;
        end
        S_M3: state <= S_M4;
        S_M4: begin
          msq_q <= mul_p[51:12];
          state <= S_M5;
        end
        S_M5: begin
          t1_q  <= mul_p[52:0];
          state <= S_M6;
        end
        S_M6: begin
          sq_v     <= 64'(var_w);
          sq_res   <= 64'd0;
          sq_bit   <= 64'd1 << 62;
          var_zero <= (var_w == 54'd0);
          state    <= S_SQRT;
        end
        S_SQRT: begin
          if (sq_v >= sq_trial) begin
            sq_v   <= sq_v - sq_trial;
            sq_res <= (sq_res >> 1) + sq_bit;
          end else begin
            sq_res <= sq_res >> 1;
          end
          sq_bit <= sq_bit >> 2;
          if (sq_bit == 64'd1) begin
            state <= S_DEV;
          end
        end
        S_DEV: begin
          dev_q <= dev_w;
          if (dev_w < 28'({deviation_low, 6'd0})) begin
            result.window_row    <= win_r;
            result.window_col    <= win_c;
            result.detected      <= 1'b0;
            result.prefiltered   <= 1'b1;
            result.stages_passed <= 6'd0;
            done  <= 1'b1;
            state <= S_IDLE;
          end else begin
            nst    <= (32'(stages_in_use) > MAX_STAGES) ? 6'(MAX_STAGES) : stages_in_use;
            k      <= 6'd0;
            fi     <= '0;
            passed <= 6'd0;
            state  <= S_STG_A;
          end
        end
        S_STG_A: begin
          if (k == nst) begin
            result.window_row    <= win_r;
            result.window_col    <= win_c;
            result.detected      <= 1'b1;
            result.prefiltered   <= 1'b0;
            result.stages_passed <= passed;
            done  <= 1'b1;
            state <= S_IDLE;
          end else begin
            state <= S_STG_B;
          end
        end
        S_STG_B: begin
          stg_q <= stg_rd;
          t_cnt <= 10'd0;
          sum   <= '0;
          state <= S_FT_CHK;
        end
        S_FT_CHK: begin
          state <= (t_cnt == stg_q.count) ? S_STG_END : S_FT_RD;
        end
        S_FT_RD: begin
          feat_q <= feat_rd;
          j      <= 4'd0;
          f_acc  <= '0;
          state  <= S_TERM_A;
        end
        S_TERM_A: begin
          oob_q <= rd_oob;
          neg_q <= rd_neg;
          mag_q <= rd_mag;
          state <= S_TERM_B;
        end
        S_TERM_B: begin
          f_acc <= neg_q ? f_acc - 46'(scaled) : f_acc + 46'(scaled);
          j     <= j + 4'd1;
          state <= (j == 4'd8) ? S_FT_MUL : S_TERM_A;
        end
        S_FT_MUL: state <= S_FT_CMP;
        S_FT_CMP: begin
          if (take) begin
            sum <= sum + 48'(feat_q.alpha);
          end
          fi    <= (32'(fi) == MAX_FEATURES - 1) ? '0 : fi + 1'b1;
          t_cnt <= t_cnt + 10'd1;
          state <= S_FT_CHK;
        end
        S_STG_END: begin
          if (sum < 48'(stg_q.thresh)) begin
            result.window_row    <= win_r;
            result.window_col    <= win_c;
            result.detected      <= 1'b0;
            result.prefiltered   <= 1'b0;
            result.stages_passed <= passed;
            done  <= 1'b1;
            state <= S_IDLE;
          end else begin
            passed <= passed + 6'd1;
            k      <= k + 6'd1;
            state  <= S_STG_A;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result beat while busy");
  a_flags: assert property (@(posedge clk) disable iff (rst)
    done |-> !(result.detected && result.prefiltered))
    else $error("detected and prefiltered both set");
  a_eval_busy: assert property (@(posedge clk) disable iff (rst)
    (fire && item.action == ACT_EVAL) |=> busy)
    else $error("evaluate did not start");
  a_all_passed: assert property (@(posedge clk) disable iff (rst)
    (done && result.detected) |-> result.stages_passed == nst)
    else $error("detected with stages missing");

endmodule

>>> tb/haar_cascade_window_evaluator_tb.sv
// Self-checking testbench: loads images and a cascade, evaluates windows, checks every verdict.
`timescale 1ns / 1ps
module haar_cascade_window_evaluator_tb;
  import hce_pkg::*;

  localparam int CYCLE_LIMIT = 100000000;
  localparam int RANDOM_PHASES = 7;
  localparam int ITEMS_PER_PHASE = 245;

  typedef enum logic [1:0] {ROW_ITEM, ROW_REG} row_kind_t;

  typedef struct {
    row_kind_t kind;
    item_t     beat;
    logic [2:0]  reg_index;
    logic [31:0] reg_value;
    bit        typed;
    result_t   verdict;
  } stim_row_t;

  logic    clk;
  logic    rst;
  logic    start;
  logic    busy;
  item_t   item;
  logic    done;
  result_t result;
  logic    cfg_valid;
  logic    cfg_ready;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;

  haar_cascade_window_evaluator dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .item(item),
    .done(done), .result(result), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Mirror of the block state.
  longint unsigned integral_img [IMG_ROWS*IMG_COLS];
  longint unsigned square_img   [IMG_ROWS*IMG_COLS];
  feat_t  feature_bank [MAX_FEATURES];
  stage_t stage_bank   [MAX_STAGES];
  logic [5:0]  win_rows, win_cols, stages_used;
  logic [23:0] mean_lo, mean_hi, inv_area;
  logic [31:0] square_lo;
  logic [7:0]  dev_lo;

  result_t pending_verdicts[$];
  result_t typed_verdicts[int];
  int issued_beats, accepted_beats;
  int errors, cycles, windows_seen, windows_detected, windows_prefiltered;
  stim_row_t directed_rows[$];

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d verdicts still pending", $time, pending_verdicts.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic void apply_reg(logic [2:0] idx, logic [31:0] data);
    case (idx)
      CFG_WIN_ROWS: win_rows    = data[5:0];
      CFG_WIN_COLS: win_cols    = data[5:0];
      CFG_MEAN_LO:  mean_lo     = data[23:0];
      CFG_MEAN_HI:  mean_hi     = data[23:0];
      CFG_SQ_LO:    square_lo   = data;
      CFG_DEV_LO:   dev_lo      = data[7:0];
      CFG_STAGES:   stages_used = data[5:0];
      CFG_INV_AREA: inv_area    = data[23:0];
      default: ;
    endcase
  endfunction

  function automatic longint img_at(bit squared, int r, int c);
    if (r >= IMG_ROWS || c >= IMG_COLS) return 0;
    return squared ? longint'(square_img[r*IMG_COLS+c]) : longint'(integral_img[r*IMG_COLS+c]);
  endfunction

  function automatic longint box_sum(bit squared, int r, int c);
    return img_at(squared, r + win_rows, c + win_cols) + img_at(squared, r, c)
         - img_at(squared, r + win_rows, c) - img_at(squared, r, c + win_cols);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'h4000000000000000;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - res - bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic longint haar_response(feat_t f, int r, int c);
    int x1, x2, x3, x4, y1, y2, y3, y4;
    x1 = r + f.offsets[4:0];   x2 = r + f.offsets[9:5];
    x3 = r + f.offsets[14:10]; x4 = r + f.offsets[19:15];
    y1 = c + f.offsets[24:20]; y2 = c + f.offsets[29:25];
    y3 = c + f.offsets[34:30]; y4 = c + f.offsets[39:35];
    case (f.kind)
      3'd0: return img_at(0,x1,y3) - img_at(0,x1,y1) + img_at(0,x3,y3) - img_at(0,x3,y1)
                 + 2 * (img_at(0,x2,y1) - img_at(0,x2,y3));
      3'd1: return img_at(0,x3,y1) + img_at(0,x3,y3) - img_at(0,x1,y1) - img_at(0,x1,y3)
                 + 2 * (img_at(0,x1,y2) - img_at(0,x3,y2));
      3'd2: return img_at(0,x1,y1) - img_at(0,x1,y3) + img_at(0,x4,y3) - img_at(0,x4,y1)
                 + 3 * (img_at(0,x2,y3) - img_at(0,x2,y1) + img_at(0,x3,y1) - img_at(0,x3,y3));
      3'd3: return img_at(0,x1,y1) - img_at(0,x1,y4) + img_at(0,x3,y4) - img_at(0,x3,y1)
                 + 3 * (img_at(0,x3,y2) - img_at(0,x3,y3) + img_at(0,x1,y3) - img_at(0,x1,y2));
      3'd4: return img_at(0,x1,y1) + img_at(0,x1,y3) + img_at(0,x3,y1) + img_at(0,x3,y3)
                 - 2 * (img_at(0,x2,y1) + img_at(0,x2,y3) + img_at(0,x1,y2) + img_at(0,x3,y2))
                 + 4 * img_at(0,x2,y2);
      default: return 0;
    endcase
  endfunction

  // Update the mirror with one beat; return 1 with the verdict for an evaluate.
  function automatic bit cascade_verdict(item_t it, output result_t v);
    longint ex, sq, sum, fr, lim, th, alpha;
    longint unsigned m, msq, sqm, var_q, dev, usq;
    int nst, fi;
    bit det, pre, below;
    int passed;
    feat_t f;
    v = '0;
    case (it.action)
      ACT_WR_INT:  begin
        integral_img[it.row*IMG_COLS+it.col] = 64'(it.entry_value);
        return 0;
      end
      ACT_WR_SQ:   begin
        square_img[it.row*IMG_COLS+it.col] = 64'(it.entry_value);
        return 0;
      end
      ACT_WR_FEAT: begin
        feature_bank[it.slot] = '{it.feature_kind, it.feature_offsets, it.feature_parity,
                                  it.feature_threshold, it.weight};
        return 0;
      end
      ACT_WR_STAGE: begin
        if (it.slot < MAX_STAGES) stage_bank[it.slot] = '{it.feature_count, it.weight};
        return 0;
      end
      ACT_EVAL: ;
      default: return 0;
    endcase
    det = 0; pre = 0; passed = 0;
    ex = box_sum(0, it.row, it.col);
    sq = box_sum(1, it.row, it.col);
    if (ex < longint'(mean_lo) || ex > longint'(mean_hi) || sq < longint'(square_lo)) begin
      pre = 1;
    end else begin
      usq = sq;
      m = (longint'(ex) * longint'(inv_area)) >> 12;
      if (m > 64'd67108863) m = 64'd67108863;
      msq = (m * m) >> 12;
      sqm = (usq >> 12) * inv_area + (((usq & 64'hFFF) * inv_area) >> 12);
      var_q = (sqm > msq) ? sqm - msq : 0;
      dev = (var_q != 0) ? int_sqrt(var_q) : 64;
      if (dev < longint'(dev_lo) * 64) begin
        pre = 1;
      end else begin
        nst = (stages_used > MAX_STAGES) ? MAX_STAGES : stages_used;
        fi = 0;
        det = 1;
        for (int k = 0; k < nst; k++) begin
          sum = 0;
          for (int t = 0; t < stage_bank[k].count; t++) begin
            f = feature_bank[fi % MAX_FEATURES];
            fi++;
            fr = haar_response(f, it.row, it.col);
            th = f.thresh;
            alpha = f.alpha;
            lim = longint'(dev) * th;
            if (fr > 64'sd1099511627776) fr = 64'sd1099511627776;
            if (fr < -64'sd1099511627776) fr = -64'sd1099511627776;
            below = (fr * 64'sd4194304) < lim;
            if (f.parity ? below : !below) sum += alpha;
          end
          th = stage_bank[k].thresh;
          if (sum < th) begin
            det = 0;
            break;
          end
          passed++;
        end
      end
    end
    v.window_row = it.row;
    v.window_col = it.col;
    v.detected = det;
    v.prefiltered = pre;
    v.stages_passed = passed[5:0];
    return 1;
  endfunction

  // Scoreboard: verdicts are popped before the beat of the same edge is queued.
  always @(posedge clk) begin
    result_t want, got, fresh;
    if (!rst) begin
      if (done) begin
        got = result;
        if (pending_verdicts.size() == 0) begin
          errors++;
          $display("%0t: verdict with none expected: %p", $time, got);
        end else begin
          want = pending_verdicts.pop_front();
          if (got.window_row != want.window_row) begin
            errors++;
            $display("%0t: window_row exp %0d got %0d", $time, want.window_row, got.window_row);
          end
          if (got.window_col != want.window_col) begin
            errors++;
            $display("%0t: window_col exp %0d got %0d", $time, want.window_col, got.window_col);
          end
          if (got.detected !== want.detected) begin
            errors++;
            $display("%0t: detected exp %0b got %0b at (%0d,%0d)", $time,
                     want.detected, got.detected, want.window_row, want.window_col);
          end
          if (got.prefiltered !== want.prefiltered) begin
            errors++;
            $display("%0t: prefiltered exp %0b got %0b at (%0d,%0d)", $time,
                     want.prefiltered, got.prefiltered, want.window_row, want.window_col);
          end
          if (got.stages_passed != want.stages_passed) begin
            errors++;
            $display("%0t: stages_passed exp %0d got %0d at (%0d,%0d)", $time,
                     want.stages_passed, got.stages_passed, want.window_row, want.window_col);
          end
        end
      end
      if (cfg_valid && cfg_ready) apply_reg(cfg_index, cfg_data);
      if (start && !busy) begin
        if (cascade_verdict(item, fresh)) begin
          windows_seen++;
          if (fresh.detected) windows_detected++;
          if (fresh.prefiltered) windows_prefiltered++;
          if (typed_verdicts.exists(accepted_beats)) fresh = typed_verdicts[accepted_beats];
          pending_verdicts.insert(pending_verdicts.size(), fresh);
        end
        accepted_beats++;
      end
    end
  end

  function automatic int idle_gap();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 60) return 0;
    if (pick < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Leaves start high when no gap follows, so back-to-back beats stay continuous.
  task automatic send_beat(item_t it);
    int gap;
    start <= 1'b1;
    item <= it;
    issued_beats++;
    do @(posedge clk); while (busy);
    gap = idle_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Step the clock first so a beat taken at the last edge is already queued.
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending_verdicts.size() != 0 || busy) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] data);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  function automatic item_t eval_beat(int r, int c);
    item_t it;
    it = '0;
    it.action = ACT_EVAL;
    it.row = 6'(r);
    it.col = 6'(c);
    return it;
  endfunction

  function automatic item_t feature_beat(int slot, int kind, logic [39:0] offs, bit parity,
                                         logic [31:0] thr, logic [31:0] alpha);
    item_t it;
    it = '0;
    it.action = ACT_WR_FEAT;
    it.slot = 10'(slot);
    it.feature_kind = 3'(kind);
    it.feature_offsets = offs;
    it.feature_parity = parity;
    it.feature_threshold = thr;
    it.weight = alpha;
    return it;
  endfunction

  function automatic item_t stage_beat(int slot, int count, logic [31:0] thr);
    item_t it;
    it = '0;
    it.action = ACT_WR_STAGE;
    it.slot = 10'(slot);
    it.feature_count = 10'(count);
    it.weight = thr;
    return it;
  endfunction

  function automatic logic [39:0] short_offsets();
    logic [39:0] o;
    for (int k = 0; k < 8; k++) o[5*k +: 5] = 5'($urandom_range(0, 12));
    return o;
  endfunction

  function automatic item_t random_feature(int slot);
    return feature_beat(slot, ($urandom_range(0, 9) == 0) ? $urandom_range(5, 7)
                        : $urandom_range(0, 4),
                        ($urandom_range(0, 3) == 0) ? 40'({$urandom, $urandom})
                        : short_offsets(),
                        $urandom_range(0, 1),
                        ($urandom_range(0, 5) == 0) ? $urandom
                        : $urandom_range(0, 32'h2000000) - 32'h1000000,
                        $urandom_range(0, 32'h80000) - 32'h40000);
  endfunction

  function automatic item_t random_beat();
    item_t it;
    logic [191:0] noise;
    int pick;
    noise = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    it = noise[$bits(item_t)-1:0];
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      it.action = ACT_EVAL;
      if ($urandom_range(0, 3) != 0) begin
        it.row = 6'($urandom_range(0, 40));
        it.col = 6'($urandom_range(0, 40));
      end
    end else if (pick < 63) begin
      it.action = $urandom_range(0, 1) ? ACT_WR_INT : ACT_WR_SQ;
      if ($urandom_range(0, 3) != 0) it.entry_value = 40'($urandom_range(0, 2000000));
    end else if (pick < 80) begin
      it = random_feature(it.slot);
    end else if (pick < 93) begin
      it.action = ACT_WR_STAGE;
      if ($urandom_range(0, 1) != 0) begin
        it.slot = 10'($urandom_range(0, MAX_STAGES - 1));
        it.feature_count = 10'($urandom_range(0, 4));
        it.weight = $urandom_range(0, 32'h100000) - 32'h80000;
      end else if (it.slot < MAX_STAGES) begin
        it.slot = 10'(it.slot + MAX_STAGES);
      end
    end else begin
      it.action = 3'($urandom_range(5, 7));
    end
    return it;
  endfunction

  task automatic load_stores();
    longint unsigned pix, sumr, sumq;
    item_t it;
    for (int r = 0; r < IMG_ROWS; r++) begin
      for (int c = 0; c < IMG_COLS; c++) begin
        sumr = 0;
        sumq = 0;
        if (r > 0 && c > 0) begin
          pix = ($urandom_range(0, 4) == 0) ? 64'd128 : 64'($urandom_range(0, 255));
          sumr = pix + integral_img[(r-1)*IMG_COLS+c] + integral_img[r*IMG_COLS+c-1]
               - integral_img[(r-1)*IMG_COLS+c-1];
          sumq = pix*pix + square_img[(r-1)*IMG_COLS+c] + square_img[r*IMG_COLS+c-1]
               - square_img[(r-1)*IMG_COLS+c-1];
        end
        it = '0;
        it.row = 6'(r);
        it.col = 6'(c);
        it.action = ACT_WR_INT;
        it.entry_value = 40'(sumr);
        send_beat(it);
        it.action = ACT_WR_SQ;
        it.entry_value = 40'(sumq);
        send_beat(it);
      end
    end
    for (int s = 0; s < MAX_FEATURES; s++) send_beat(random_feature(s));
    for (int s = 0; s < MAX_STAGES; s++)
      send_beat(stage_beat(s, $urandom_range(0, 4), $urandom_range(0, 32'h100000) - 32'h80000));
  endtask

  task automatic add_row(row_kind_t kind, item_t it, logic [2:0] idx, logic [31:0] data,
                         bit typed, result_t verdict);
    stim_row_t row;
    row.kind = kind;
    row.beat = it;
    row.reg_index = idx;
    row.reg_value = data;
    row.typed = typed;
    row.verdict = verdict;
    directed_rows.insert(directed_rows.size(), row);
  endtask

  task automatic build_directed();
    item_t odd;
    odd = '1;
    add_row(ROW_ITEM, eval_beat(0, 0), 0, 0, 1, '{6'd0, 6'd0, 1'b1, 1'b0, 6'd0});
    add_row(ROW_ITEM, eval_beat(63, 63), 0, 0, 1, '{6'd63, 6'd63, 1'b1, 1'b0, 6'd0});
    odd.action = 3'd5; add_row(ROW_ITEM, odd, 0, 0, 0, '0);
    odd.action = 3'd6; add_row(ROW_ITEM, odd, 0, 0, 0, '0);
    odd.action = 3'd7; add_row(ROW_ITEM, odd, 0, 0, 0, '0);
    add_row(ROW_ITEM, feature_beat(0, 0, 40'h0, 0, 32'h80000000, 32'h7FFFFFFF), 0, 0, 0, '0);
    add_row(ROW_ITEM, feature_beat(1, 1, 40'hFFFFFFFFFF, 1, 32'h7FFFFFFF, 32'h80000000),
            0, 0, 0, '0);
    add_row(ROW_ITEM, feature_beat(2, 2, short_offsets(), 1, 32'h0, 32'h10000), 0, 0, 0, '0);
    add_row(ROW_ITEM, feature_beat(3, 3, short_offsets(), 0, 32'h0, 32'h10000), 0, 0, 0, '0);
    add_row(ROW_ITEM, feature_beat(4, 4, short_offsets(), 1, 32'h100000, 32'h8000),
            0, 0, 0, '0);
    add_row(ROW_ITEM, feature_beat(5, 7, short_offsets(), 0, 32'h0, 32'h1), 0, 0, 0, '0);
    add_row(ROW_ITEM, stage_beat(0, 6, 32'h0), 0, 0, 0, '0);
    add_row(ROW_ITEM, stage_beat(1023, 1023, 32'h80000000), 0, 0, 0, '0);
    add_row(ROW_REG, '0, CFG_STAGES, 32'd1, 0, '0);
    add_row(ROW_ITEM, eval_beat(10, 10), 0, 0, 0, '0);
    add_row(ROW_REG, '0, CFG_STAGES, 32'd63, 0, '0);
    add_row(ROW_ITEM, eval_beat(20, 5), 0, 0, 0, '0);
    add_row(ROW_REG, '0, CFG_DEV_LO, 32'd255, 0, '0);
    add_row(ROW_ITEM, eval_beat(7, 9), 0, 0, 1, '{6'd7, 6'd9, 1'b0, 1'b1, 6'd0});
    add_row(ROW_REG, '0, CFG_DEV_LO, 32'd0, 0, '0);
    add_row(ROW_REG, '0, CFG_MEAN_LO, 32'hFFFFFF, 0, '0);
    add_row(ROW_ITEM, eval_beat(3, 30), 0, 0, 1, '{6'd3, 6'd30, 1'b0, 1'b1, 6'd0});
    add_row(ROW_REG, '0, CFG_MEAN_LO, 32'd0, 0, '0);
    // walk past the end of the feature bank so the index wraps
    add_row(ROW_ITEM, stage_beat(0, 1023, 32'h80000000), 0, 0, 0, '0);
    add_row(ROW_ITEM, stage_beat(1, 3, 32'h0), 0, 0, 0, '0);
    add_row(ROW_REG, '0, CFG_STAGES, 32'd2, 0, '0);
    add_row(ROW_ITEM, eval_beat(12, 12), 0, 0, 0, '0);
    add_row(ROW_ITEM, stage_beat(0, 2, 32'h0), 0, 0, 0, '0);
  endtask

  task automatic set_phase(int p);
    int r, c;
    r = (p == 1) ? 1 : (p == 2) ? 63 : (p == 3) ? 32 : $urandom_range(4, 24);
    c = (p == 1) ? 32 : (p == 2) ? 0 : (p == 3) ? 32 : $urandom_range(4, 24);
    write_reg(CFG_WIN_ROWS, r);
    write_reg(CFG_WIN_COLS, c);
    write_reg(CFG_INV_AREA, (p == 4) ? 32'd0 : (p == 2) ? 32'hFFFFFF
                            : (32'd1 << 24) / ((r + 1) * (c + 1)));
    write_reg(CFG_MEAN_LO, (p == 4) ? $urandom_range(0, 5000) : 0);
    write_reg(CFG_MEAN_HI, (p == 4 || p == 6) ? $urandom_range(20000, 200000) : 32'hFFFFFF);
    write_reg(CFG_SQ_LO, (p == 3) ? 32'hFFFFFFFF : (p == 4) ? $urandom_range(0, 1000000) : 0);
    write_reg(CFG_DEV_LO, (p == 6) ? 255 : $urandom_range(0, 2));
    write_reg(CFG_STAGES, (p == 5) ? 32 : (p == 2) ? 40 : $urandom_range(1, 6));
  endtask

  initial begin
    stim_row_t row;
    start = 1'b0;
    item = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    errors = 0;
    cycles = 0;
    issued_beats = 0;
    accepted_beats = 0;
    windows_seen = 0;
    windows_detected = 0;
    windows_prefiltered = 0;
    win_rows = 24; win_cols = 24;
    mean_lo = 0; mean_hi = 24'hFFFFFF;
    square_lo = 0; dev_lo = 0;
    stages_used = 0; inv_area = 24'd26843;
    rst = 1'b1;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    load_stores();
    build_directed();
    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.kind == ROW_REG) begin
        write_reg(row.reg_index, row.reg_value);
      end else begin
        if (row.typed) typed_verdicts[issued_beats] = row.verdict;
        send_beat(row.beat);
      end
    end

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      set_phase(p);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) send_beat(random_beat());
    end

    drain();
    repeat (50) @(posedge clk);
    $display("Evaluated %0d windows (%0d detected, %0d prefiltered) over %0d beats,",
             windows_seen, windows_detected, windows_prefiltered, accepted_beats);
    $display("across %0d register settings, in %0d cycles.", RANDOM_PHASES + 1, cycles);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
